// ----- rtl/core/tcw_pkg.sv -----
// tcw_pkg: shared types, constants and helpers of the text console writer
// no dependencies; imported by every module of the core except tcw_ram

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // field widths
  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_W      = CHAR_W + ATTR_W;
  localparam int CURSOR_W    = 11;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // operation codes carried in tuser
  localparam logic [MODE_W-1:0] MODE_PUT       = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NEWLINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BACKSPACE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 2'd3;

  // blank cell contents
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // request from the cursor logic to the memory sweep engine
  typedef struct packed {
    logic scroll;
    logic clear;
  } sweep_req_t;

  // cell layout: attribute in the high byte, character in the low byte
  function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                  input logic [CHAR_W-1:0] ch);
    make_cell = {attr, ch};
  endfunction

endpackage

// ----- rtl/core/tcw_ram.sv -----
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/tcw_cursor.sv -----
// tcw_cursor: cursor row, column and cell index, per-operation cell write and sweep request
// depends on tcw_pkg

module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int CELLS   = ROWS * COLUMNS,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [MODE_W-1:0] mode,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ATTR_W-1:0] attr,
  output logic [ADDR_W-1:0] pos_next,
  output logic              scrolled,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [CELL_W-1:0] wr_cell,
  output sweep_req_t        req
);

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_POS = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);

  logic [ROW_W-1:0]  row, row_next;
  logic [COL_W-1:0]  col, col_next;
  logic [ADDR_W-1:0] pos;
  logic              op_wr;
  logic [CHAR_W-1:0] wr_char;
  sweep_req_t        op_req;

  // next cursor and side effects of one operation
  always_comb begin
    row_next = row;
    col_next = col;
    pos_next = pos;
    scrolled = 1'b0;
    op_wr    = 1'b0;
    wr_addr  = pos;
    wr_char  = char_code;
    op_req   = '0;
    case (mode)
      MODE_PUT: begin
        op_wr = 1'b1;
        if (col == LAST_COL) begin
          col_next = '0;
          if (row == LAST_ROW) begin
            scrolled      = 1'b1;
            op_req.scroll = 1'b1;
            pos_next      = BOTTOM_POS;
          end else begin
            row_next = row + 1'b1;
            pos_next = pos + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
          pos_next = pos + 1'b1;
        end
      end
      MODE_NEWLINE: begin
        col_next = '0;
        if (row == LAST_ROW) begin
          scrolled      = 1'b1;
          op_req.scroll = 1'b1;
          pos_next      = BOTTOM_POS;
        end else begin
          row_next = row + 1'b1;
          pos_next = pos - ADDR_W'(col) + ROW_STEP;
        end
      end
      MODE_BACKSPACE: begin
        // at cell zero nothing changes
        if (pos != '0) begin
          op_wr    = 1'b1;
          pos_next = pos - 1'b1;
          wr_addr  = pos - 1'b1;
          wr_char  = BLANK_CHAR;
          if (col == '0) begin
            col_next = LAST_COL;
            row_next = row - 1'b1;
          end else begin
            col_next = col - 1'b1;
          end
        end
      end
      default: begin
        row_next     = '0;
        col_next     = '0;
        pos_next     = '0;
        op_req.clear = 1'b1;
      end
    endcase
  end

  assign wr_en   = in_fire & op_wr;
  assign wr_cell = make_cell(attr, wr_char);
  assign req     = in_fire ? op_req : '0;

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      pos <= '0;
    end else if (in_fire) begin
      row <= row_next;
      col <= col_next;
      pos <= pos_next;
    end
  end

  // cell index always agrees with row and column
  a_pos_matches: assert property (@(posedge clk) disable iff (rst)
    pos == ADDR_W'(row * COLUMNS + col))
    else $error("cursor index out of step with row and column");

endmodule

// ----- rtl/core/tcw_sweep.sv -----
// tcw_sweep: sequencer that walks the cell memory for reset fill, clear and scroll
// depends on tcw_pkg

module tcw_sweep import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  parameter int CELLS   = ROWS * COLUMNS,
  parameter int ADDR_W  = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  sweep_req_t        req,
  input  logic [ATTR_W-1:0] attr,
  output logic              busy,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [CELL_W-1:0] rd_data,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [CELL_W-1:0] wr_data
);

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;
  localparam logic [1:0] ST_BLANK = 2'd3;

  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SHIFT_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLUMNS);

  logic [1:0]        state;
  logic [ADDR_W-1:0] idx;
  logic [ATTR_W-1:0] fill_attr;

  assign busy = (state != ST_IDLE);

  // shift reads one row ahead; the write of the previous read follows in the next cycle
  always_comb begin
    rd_en   = (state == ST_SHIFT) && (idx != SHIFT_LAST);
    rd_addr = idx + ROW_STEP;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = make_cell(fill_attr, BLANK_CHAR);
    case (state)
      ST_INIT, ST_BLANK: begin
        wr_en = 1'b1;
      end
      ST_SHIFT: begin
        wr_en   = (idx != '0);
        wr_addr = idx - 1'b1;
        wr_data = rd_data;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sweep sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      idx       <= '0;
      fill_attr <= RESET_ATTR;
    end else begin
      case (state)
        ST_INIT, ST_BLANK: begin
          if (idx == CELL_LAST) begin
            state <= ST_IDLE;
            idx   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_SHIFT: begin
          // bottom row blanking starts where the last shifted write ends
          if (idx == SHIFT_LAST) begin
            state <= ST_BLANK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
          if (req.clear) begin
            state     <= ST_BLANK;
            idx       <= '0;
            fill_attr <= attr;
          end else if (req.scroll) begin
            state     <= ST_SHIFT;
            idx       <= '0;
            fill_attr <= attr;
          end
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/text_console_writer_core.sv -----
// text_console_writer_core: top level of the text console writer
// depends on tcw_pkg, tcw_ram, tcw_cursor and tcw_sweep

// Each input transaction carries one operation in tuser (put char, newline,
// backspace, clear) and a character in tdata, and yields exactly one output
// transaction with the cursor cell index after the operation and a scroll
// flag. Put char, newline and backspace that do not scroll go at one per
// cycle while the sink keeps accepting; the result sits in an output register
// and the next item is taken no earlier than the cycle in which the sink
// accepts that result. A clear occupies the cell memory write port while it
// blanks every cell, and a scroll while it moves each cell up one row (one
// cell moved per cycle through the registered read port) and then blanks the
// bottom row; no item is accepted meanwhile, though the result is already
// delivered. After reset the cell memory is filled with blanks before the
// first item is accepted; attribute writes are taken at any time.

module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // attribute register write
  input  logic                   cfg_wen,
  input  logic [ATTR_W-1:0]      cfg_wdata,
  // operation input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [MODE_W-1:0]      s_axis_tuser,   // [1:0] mode
  // cursor result output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] cursor_cell, rest zero
  output logic [0:0]             m_axis_tuser    // [0] scrolled
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  logic [ATTR_W-1:0] text_attribute;
  logic              s_fire;
  logic              busy;
  sweep_req_t        req;

  logic [ADDR_W-1:0] pos_next;
  logic              scrolled;
  logic              cur_wr_en;
  logic [ADDR_W-1:0] cur_wr_addr;
  logic [CELL_W-1:0] cur_wr_cell;

  logic              sw_rd_en;
  logic [ADDR_W-1:0] sw_rd_addr;
  logic              sw_wr_en;
  logic [ADDR_W-1:0] sw_wr_addr;
  logic [CELL_W-1:0] sw_wr_data;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [CELL_W-1:0] ram_wr_data;
  logic [CELL_W-1:0] ram_rd_data;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= RESET_ATTR;
    end else if (cfg_wen) begin
      text_attribute <= cfg_wdata;
    end
  end

  // input accepted when no sweep runs and the output register can take the result
  assign s_axis_tready = !busy && (!m_axis_tvalid || m_axis_tready);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .ADDR_W  (ADDR_W)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (s_fire),
    .mode      (s_axis_tuser),
    .char_code (s_axis_tdata[CHAR_W-1:0]),
    .attr      (text_attribute),
    .pos_next  (pos_next),
    .scrolled  (scrolled),
    .wr_en     (cur_wr_en),
    .wr_addr   (cur_wr_addr),
    .wr_cell   (cur_wr_cell),
    .req       (req)
  );

  tcw_sweep #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .CELLS   (CELLS),
    .ADDR_W  (ADDR_W)
  ) u_sweep (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .attr    (text_attribute),
    .busy    (busy),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (sw_wr_en),
    .wr_addr (sw_wr_addr),
    .wr_data (sw_wr_data)
  );

  // write port shared: cursor writes only happen while the sweep is idle
  assign ram_wr_en   = sw_wr_en | cur_wr_en;
  assign ram_wr_addr = sw_wr_en ? sw_wr_addr : cur_wr_addr;
  assign ram_wr_data = sw_wr_en ? sw_wr_data : cur_wr_cell;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (sw_rd_en),
    .rd_addr (sw_rd_addr),
    .rd_data (ram_rd_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_axis_tdata <= OUT_TDATA_W'(CURSOR_W'(pos_next));
      m_axis_tuser <= scrolled;
    end
  end

  // no item taken while the memory is being walked
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready)
    else $error("input accepted during a memory sweep");

  // every accepted item leaves a result in the output register
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> m_axis_tvalid)
    else $error("accepted item produced no result");

  // a scrolled result always puts the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[CURSOR_W-1:0] == CURSOR_W'((ROWS - 1) * COLUMNS)))
    else $error("scroll left the cursor off the bottom row start");

  // a clear or a scroll starts a memory sweep
  a_sweep_starts: assert property (@(posedge clk) disable iff (rst)
    (req.clear || req.scroll) |=> busy)
    else $error("sweep request did not start the sequencer");

endmodule
